### src/assert_macros.svh
// Assertion helpers shared by the mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define SBM_ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SBM_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SBM_ASSERT_PROP(label, clk, rst, prop, msg)
`define SBM_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

### src/sbm_pkg.sv
package sbm_pkg;

   // Address translation width of the program ROM.
   localparam int PrgAddrBitsDefault = 19;

   // Bus commands.
   localparam logic [1:0] CMD_CPU_READ  = 2'd0;
   localparam logic [1:0] CMD_CPU_WRITE = 2'd1;
   localparam logic [1:0] CMD_PPU_READ  = 2'd2;
   localparam logic [1:0] CMD_PPU_WRITE = 2'd3;

   // Result targets.
   localparam logic [2:0] TGT_PRG_ROM   = 3'd0;
   localparam logic [2:0] TGT_PRG_RAM   = 3'd1;
   localparam logic [2:0] TGT_CHR       = 3'd2;
   localparam logic [2:0] TGT_NAMETABLE = 3'd3;
   localparam logic [2:0] TGT_PALETTE   = 3'd4;
   localparam logic [2:0] TGT_REGISTER  = 3'd5;
   localparam logic [2:0] TGT_UNMAPPED  = 3'd6;

   // Mapper register numbers (CPU address bits 14:13).
   localparam logic [1:0] REG_CONTROL = 2'd0;
   localparam logic [1:0] REG_CHR0    = 2'd1;
   localparam logic [1:0] REG_CHR1    = 2'd2;
   localparam logic [1:0] REG_PRG     = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_CHR_IS_RAM     = 1'b0;
   localparam logic CSR_PRG_BANK_COUNT = 1'b1;

   // Reset values.
   localparam logic [4:0] CONTROL_RESET    = 5'h0C;
   localparam logic [4:0] CHR_HIGH_RESET   = 5'h01;
   localparam logic [5:0] BANK_COUNT_RESET = 6'd2;

   // PRG modes (control bits 3:2).
   localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
   localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

   // Mirroring (control bits 1:0).
   localparam logic [1:0] MIRROR_ONE_LOW  = 2'd0;
   localparam logic [1:0] MIRROR_ONE_HIGH = 2'd1;
   localparam logic [1:0] MIRROR_VERTICAL = 2'd2;

   localparam logic [2:0] SERIAL_LAST = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] bus_address;
      logic [7:0]  bus_data;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  target;
      logic [18:0] mem_address;
      logic        write_enable;
      logic        bank_update;
   } rsp_item_type;

   // One serial-port write towards the loader.
   typedef struct packed {
      logic       strobe;
      logic [1:0] which;
      logic [7:0] data;
   } load_type;

   // Committed bank registers.
   typedef struct packed {
      logic [4:0] control;
      logic [4:0] chr_low;
      logic [4:0] chr_high;
      logic [3:0] prg_select;
      logic       prg_outer_half;
   } banks_type;

endpackage

### src/sbm_serial_loader.sv
`include "assert_macros.svh"

module sbm_serial_loader (
   input  logic               clock,
   input  logic               reset,
   input  logic               chr_is_ram,
   input  sbm_pkg::load_type  load,
   output sbm_pkg::banks_type banks,
   output logic               commit
);
   import sbm_pkg::*;

   logic [4:0] serial_value_ff, serial_value_in;
   logic [2:0] serial_count_ff, serial_count_in;
   banks_type  banks_ff, banks_in;
   logic [4:0] shifted;

   always_comb begin
      serial_value_in = serial_value_ff;
      serial_count_in = serial_count_ff;
      banks_in        = banks_ff;
      commit          = 1'b0;
      shifted         = serial_value_ff | (5'(load.data[0]) << serial_count_ff);
      if (load.strobe) begin
         if (load.data[7]) begin
            serial_value_in       = '0;
            serial_count_in       = '0;
            banks_in.control[3:2] = 2'b11;
         end else if (serial_count_ff == SERIAL_LAST) begin
            serial_value_in = '0;
            serial_count_in = '0;
            commit          = 1'b1;
            case (load.which)
               REG_CONTROL: banks_in.control = shifted;
               REG_CHR0: begin
                  banks_in.chr_low = shifted;
                  if (chr_is_ram) begin
                     banks_in.prg_outer_half = shifted[4];
                  end
               end
               REG_CHR1: begin
                  banks_in.chr_high = shifted;
                  if (chr_is_ram && banks_ff.control[4]) begin
                     banks_in.prg_outer_half = shifted[4];
                  end
               end
               default: banks_in.prg_select = shifted[3:0];
            endcase
         end else begin
            serial_value_in = shifted;
            serial_count_in = serial_count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_value_ff         <= '0;
         serial_count_ff         <= '0;
         banks_ff.control        <= CONTROL_RESET;
         banks_ff.chr_low        <= '0;
         banks_ff.chr_high       <= CHR_HIGH_RESET;
         banks_ff.prg_select     <= '0;
         banks_ff.prg_outer_half <= 1'b0;
      end else begin
         serial_value_ff <= serial_value_in;
         serial_count_ff <= serial_count_in;
         banks_ff        <= banks_in;
      end
   end

   assign banks = banks_ff;

   `SBM_ASSERT_NEVER(a_count_range, clock, reset, serial_count_ff > SERIAL_LAST, "serial count beyond fifth bit")
   `SBM_ASSERT_PROP(a_commit_clears, clock, reset, commit |=> (serial_count_ff == 3'd0 && serial_value_ff == 5'd0), "shift register not cleared after commit")
   `SBM_ASSERT_PROP(a_serial_reset, clock, reset, (load.strobe && load.data[7]) |=> (banks_ff.control[3:2] == 2'b11 && serial_count_ff == 3'd0), "serial reset did not fix last bank")

endmodule

### src/serial_bank_mapper.sv
// Serial-loaded bank mapper: translates one CPU or PPU bus access per transaction.
//
// Request channel (req_valid / req_stall / req_item): one bus access with its
// command, 16-bit address and write data. Response channel (rsp_valid /
// rsp_stall / rsp_item): the target memory, translated address, write enable
// and a flag that marks the fifth serial write which committed a register.
// Every request yields exactly one response, in order.
// An accepted transaction is registered in the output register, or in the skid
// register while the receiver stalls. Throughput is one transaction per cycle
// when the receiver does not stall, set by the single translation stage and
// the mapper state updated in the same cycle as the access it belongs to.
// When the receiver stalls, the response holds and one more transaction is
// caught in a skid register; req_stall then rises until the skid drains.
// Reset (synchronous, active high) empties both registers, clears the serial
// shift state and loads control 0x0C (last bank fixed), CHR0 0, CHR1 1,
// PRG 0; configuration returns to chr_is_ram 0 and prg_bank_count 2.
// Configuration sits on an APB-style port: chr_is_ram at 0x0, prg_bank_count
// at 0x4; write only while no transaction is outstanding.

`include "assert_macros.svh"

module serial_bank_mapper #(
   parameter int PRG_ADDR_BITS = sbm_pkg::PrgAddrBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sbm_pkg::req_item_type req_item,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sbm_pkg::rsp_item_type rsp_item,
   // Configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import sbm_pkg::*;

   localparam logic [19:0] PrgMaskWide = (20'd1 << PRG_ADDR_BITS) - 20'd1;
   localparam logic [18:0] PrgMask     = PrgMaskWide[18:0];

   // Configuration registers
   logic       chr_is_ram_ff;
   logic [5:0] prg_bank_count_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         chr_is_ram_ff     <= 1'b0;
         prg_bank_count_ff <= BANK_COUNT_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            CSR_CHR_IS_RAM:     chr_is_ram_ff     <= pwdata[0];
            CSR_PRG_BANK_COUNT: prg_bank_count_ff <= pwdata[5:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_CHR_IS_RAM:     prdata = {31'd0, chr_is_ram_ff};
         CSR_PRG_BANK_COUNT: prdata = {26'd0, prg_bank_count_ff};
         default:            prdata = '0;
      endcase
   end

   // Handshake: the skid register is the only thing that can block a request
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         accept;
   logic         out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // Serial loader sees every CPU write at $8000 and above
   load_type  load;
   banks_type banks;
   logic      commit;

   assign load.strobe = accept && (req_item.cmd == CMD_CPU_WRITE) && req_item.bus_address[15];
   assign load.which  = req_item.bus_address[14:13];
   assign load.data   = req_item.bus_data;

   sbm_serial_loader u_loader (
      .clock      (clock),
      .reset      (reset),
      .chr_is_ram (chr_is_ram_ff),
      .load       (load),
      .banks      (banks),
      .commit     (commit)
   );

   // Translation, always from the register values held before this access
   rsp_item_type result;
   logic [15:0]  addr;
   logic [13:0]  ppu_addr;
   logic         is_write;
   logic [3:0]   last_bank;
   logic [3:0]   inner_bank;
   logic         outer_half;
   logic [18:0]  prg_full;
   logic [4:0]   chr_mask;
   logic [4:0]   chr_bank;
   logic         nt_table;
   logic [4:0]   pal_addr;

   always_comb begin
      addr       = req_item.bus_address;
      ppu_addr   = addr[13:0];
      is_write   = req_item.cmd[0];
      last_bank  = prg_bank_count_ff[3:0] - 4'd1;
      outer_half = chr_is_ram_ff && banks.prg_outer_half;

      case (banks.control[3:2])
         PRG_MODE_FIX_FIRST: inner_bank = addr[14] ? banks.prg_select : 4'd0;
         PRG_MODE_FIX_LAST:  inner_bank = addr[14] ? last_bank : banks.prg_select;
         default:            inner_bank = {banks.prg_select[3:1], addr[14]};
      endcase
      prg_full = {outer_half, inner_bank, addr[13:0]} & PrgMask;

      chr_mask = chr_is_ram_ff ? 5'h01 : 5'h1F;
      chr_bank = (ppu_addr[12] ? banks.chr_high : banks.chr_low) & chr_mask;

      case (banks.control[1:0])
         MIRROR_ONE_LOW:  nt_table = 1'b0;
         MIRROR_ONE_HIGH: nt_table = 1'b1;
         MIRROR_VERTICAL: nt_table = ppu_addr[10];
         default:         nt_table = ppu_addr[11];
      endcase

      // Fold the sprite backdrop mirrors onto the background entries
      pal_addr = ppu_addr[4:0];
      if (pal_addr[4] && pal_addr[1:0] == 2'b00) begin
         pal_addr[4] = 1'b0;
      end

      result.target       = TGT_UNMAPPED;
      result.mem_address  = '0;
      result.write_enable = 1'b0;
      result.bank_update  = commit;

      if (!req_item.cmd[1]) begin
         if (addr[15]) begin
            if (!is_write) begin
               result.target      = TGT_PRG_ROM;
               result.mem_address = prg_full;
            end else begin
               result.target       = TGT_REGISTER;
               result.mem_address  = {17'd0, addr[14:13]};
               result.write_enable = 1'b1;
            end
         end else if (addr[14:13] == 2'b11) begin
            result.target       = TGT_PRG_RAM;
            result.mem_address  = {6'd0, addr[12:0]};
            result.write_enable = is_write;
         end
      end else if (!ppu_addr[13]) begin
         result.target = TGT_CHR;
         if (banks.control[4]) begin
            result.mem_address = {2'd0, chr_bank, ppu_addr[11:0]};
         end else begin
            result.mem_address = {2'd0, banks.chr_low[4:1] & chr_mask[4:1], ppu_addr[12:0]};
         end
         result.write_enable = is_write && chr_is_ram_ff;
      end else if (ppu_addr[13:8] != 6'h3F) begin
         result.target       = TGT_NAMETABLE;
         result.mem_address  = {8'd0, nt_table, ppu_addr[9:0]};
         result.write_enable = is_write;
      end else begin
         result.target       = TGT_PALETTE;
         result.mem_address  = {14'd0, pal_addr};
         result.write_enable = is_write;
      end
   end

   // Output register and skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // Drain the skid into the output register
            out_item_in   = skid_item_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_item_in  = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         // Output held by the receiver: park the new transaction
         skid_item_in  = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   `SBM_ASSERT_PROP(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid holds a transaction while the output is empty")
   `SBM_ASSERT_PROP(a_held_result_kept, clock, reset, (out_valid_ff && rsp_stall) |=> out_valid_ff, "stalled response dropped")
   `SBM_ASSERT_PROP(a_update_is_register, clock, reset, (rsp_valid && rsp_item.bank_update) |-> (rsp_item.target == TGT_REGISTER && rsp_item.write_enable), "commit flagged on a non-register access")

endmodule
